### design/swpc_pkg.sv
// Package with the beat types, FIFO entry type, sequencer states and constants of the peak counter.
package swpc_pkg;

    localparam int unsigned FIFO_DEPTH_DEFAULT = 1024;
    localparam int unsigned WINDOW_W = 24;
    localparam int unsigned WORD_W = 32;
    localparam int unsigned APB_ADDR_W = 3;
    localparam logic [WINDOW_W-1:0] WINDOW_RESET = 24'd60;
    localparam logic [WORD_W-1:0] WORD_MAX = {WORD_W{1'b1}};
    localparam logic [0:0] REG_IDX_WINDOW = 1'b0;

    typedef struct packed {
        logic              has_time;
        logic [WORD_W-1:0] timestamp;
        logic              server_error;
    } in_beat_t;

    typedef struct packed {
        logic [WORD_W-1:0] window_count;
        logic [WORD_W-1:0] best_count;
        logic [WORD_W-1:0] best_begin;
        logic [WORD_W-1:0] best_end;
        logic [WORD_W-1:0] error_total;
        logic              overflow;
    } out_beat_t;

    typedef struct packed {
        logic [WORD_W-1:0] entry_time;
        logic [WORD_W-1:0] number;
    } entry_t;

    typedef struct packed {
        logic push;
        logic pop;
    } fifo_cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PUSH,
        ST_READ,
        ST_CHECK,
        ST_PEAK,
        ST_FINISH
    } seq_state_t;

endpackage

### design/swpc_fifo.sv
// Circular FIFO of timestamp and record number entries with a registered read of the oldest entry.
module swpc_fifo
    import swpc_pkg::*;
#(
    parameter int unsigned FIFO_DEPTH = FIFO_DEPTH_DEFAULT
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  fifo_cmd_t cmd,
    input  entry_t    wr_entry,
    output entry_t    head_entry,
    output logic      full
);

    localparam int unsigned PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int unsigned FILL_W = $clog2(FIFO_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(FIFO_DEPTH - 1);
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(FIFO_DEPTH);

    entry_t mem [FIFO_DEPTH];

    logic [PTR_W-1:0]  head_reg, head_next;
    logic [PTR_W-1:0]  tail_reg, tail_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    entry_t            rd_reg;
    logic              do_pop;

    assign full = (fill_reg == FILL_FULL);
    assign do_pop = cmd.pop && (fill_reg != '0);

    always_comb begin
        head_next = head_reg;
        tail_next = tail_reg;
        fill_next = fill_reg;
        if (do_pop) begin
            head_next = (head_reg == PTR_LAST) ? '0 : head_reg + 1'b1;
        end
        if (cmd.push) begin
            tail_next = (tail_reg == PTR_LAST) ? '0 : tail_reg + 1'b1;
        end
        if (cmd.push && !do_pop) begin
            fill_next = fill_reg + 1'b1;
        end else if (!cmd.push && do_pop) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= '0;
            tail_reg <= '0;
            fill_reg <= '0;
        end else begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            mem[tail_reg] <= wr_entry;
        end
        rd_reg <= mem[head_next];
    end

    assign head_entry = rd_reg;

endmodule

### design/sliding_window_peak_counter_core.sv
// Top level of the sliding window peak counter: sequencer, shared subtractor, peak and error state.
//
// Each input beat produces exactly one result beat. A record without a timestamp goes from acceptance
// straight to the finish state; a timestamped record passes the push, read, check and peak states,
// looping in check while entries age out of the window, as the oldest FIFO entry is examined through
// the single registered FIFO read port, one entry per cycle, with one subtractor shared between
// the age test and the window count. The input is not ready while a record is being processed;
// a finished result waits in the output register without holding back the next input beat.
// The FIFO needs no clearing after reset. The window length register sits at byte address 0.
module sliding_window_peak_counter_core
    import swpc_pkg::*;
#(
    parameter int unsigned FIFO_DEPTH = FIFO_DEPTH_DEFAULT
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_beat_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_beat_t             m_data,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [WORD_W-1:0]     pwdata,
    output logic [WORD_W-1:0]     prdata,
    output logic                  pready
);

    seq_state_t          state_reg, state_next;
    in_beat_t            item_reg, item_next;
    logic                ovf_reg, ovf_next;
    logic [WORD_W-1:0]   count_reg, count_next;
    logic [WORD_W-1:0]   begin_reg, begin_next;
    logic [WORD_W-1:0]   recnum_reg, recnum_next;
    logic [WORD_W-1:0]   peak_count_reg, peak_count_next;
    logic [WORD_W-1:0]   peak_begin_reg, peak_begin_next;
    logic [WORD_W-1:0]   peak_end_reg, peak_end_next;
    logic [WORD_W-1:0]   err_reg, err_next;
    logic [WINDOW_W-1:0] window_reg;
    logic                m_valid_reg, m_valid_next;
    out_beat_t           m_data_reg, m_data_next;

    fifo_cmd_t           fifo_cmd;
    entry_t              wr_entry;
    entry_t              head_entry;
    logic                fifo_full;

    logic [WORD_W-1:0]   sub_a, sub_b;
    logic [WORD_W:0]     sub_res;
    logic                cfg_write;

    swpc_fifo #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (fifo_cmd),
        .wr_entry   (wr_entry),
        .head_entry (head_entry),
        .full       (fifo_full)
    );

    assign wr_entry.entry_time = item_reg.timestamp;
    assign wr_entry.number = recnum_reg;

    assign sub_a = (state_reg == ST_CHECK) ? item_reg.timestamp : recnum_reg;
    assign sub_b = (state_reg == ST_CHECK) ? head_entry.entry_time : head_entry.number;
    assign sub_res = {1'b0, sub_a} - {1'b0, sub_b};

    assign pready = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[APB_ADDR_W-1] == REG_IDX_WINDOW);
    assign prdata = (paddr[APB_ADDR_W-1] == REG_IDX_WINDOW) ?
                    {{(WORD_W-WINDOW_W){1'b0}}, window_reg} : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg <= WINDOW_RESET;
        end else if (cfg_write) begin
            window_reg <= pwdata[WINDOW_W-1:0];
        end
    end

    always_comb begin
        state_next      = state_reg;
        item_next       = item_reg;
        ovf_next        = ovf_reg;
        count_next      = count_reg;
        begin_next      = begin_reg;
        recnum_next     = recnum_reg;
        peak_count_next = peak_count_reg;
        peak_begin_next = peak_begin_reg;
        peak_end_next   = peak_end_reg;
        err_next        = err_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_data_next     = m_data_reg;
        fifo_cmd        = '0;
        s_ready         = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    item_next  = s_data;
                    ovf_next   = 1'b0;
                    count_next = '0;
                    state_next = s_data.has_time ? ST_PUSH : ST_FINISH;
                end
            end
            ST_PUSH: begin
                fifo_cmd.push = 1'b1;
                fifo_cmd.pop  = fifo_full;
                ovf_next      = fifo_full;
                state_next    = ST_READ;
            end
            ST_READ: begin
                state_next = ST_CHECK;
            end
            ST_CHECK: begin
                if (!sub_res[WORD_W] &&
                    (sub_res[WORD_W-1:0] > {{(WORD_W-WINDOW_W){1'b0}}, window_reg})) begin
                    fifo_cmd.pop = 1'b1;
                end else begin
                    state_next = ST_PEAK;
                end
            end
            ST_PEAK: begin
                count_next = (sub_res[WORD_W-1:0] == WORD_MAX) ? WORD_MAX :
                             sub_res[WORD_W-1:0] + 1'b1;
                begin_next = head_entry.entry_time;
                state_next = ST_FINISH;
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    if (item_reg.has_time && (count_reg > peak_count_reg)) begin
                        peak_count_next = count_reg;
                        peak_begin_next = begin_reg;
                        peak_end_next   = item_reg.timestamp;
                    end
                    if (item_reg.server_error && (err_reg != WORD_MAX)) begin
                        err_next = err_reg + 1'b1;
                    end
                    recnum_next              = recnum_reg + 1'b1;
                    m_data_next.window_count = count_reg;
                    m_data_next.best_count   = peak_count_next;
                    m_data_next.best_begin   = peak_begin_next;
                    m_data_next.best_end     = peak_end_next;
                    m_data_next.error_total  = err_next;
                    m_data_next.overflow     = ovf_reg;
                    m_valid_next             = 1'b1;
                    state_next               = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            recnum_reg     <= '0;
            peak_count_reg <= '0;
            peak_begin_reg <= '0;
            peak_end_reg   <= '0;
            err_reg        <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            recnum_reg     <= recnum_next;
            peak_count_reg <= peak_count_next;
            peak_begin_reg <= peak_begin_next;
            peak_end_reg   <= peak_end_next;
            err_reg        <= err_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg   <= item_next;
        ovf_reg    <= ovf_next;
        count_reg  <= count_next;
        begin_reg  <= begin_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data = m_data_reg;

endmodule

### tb/tb_sliding_window_peak_counter_core.sv
// Testbench for the sliding window peak counter core with a self-checking scoreboard.
module tb_sliding_window_peak_counter_core;
    import swpc_pkg::*;

    localparam int unsigned IDLE_LIMIT = 20000;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned TAIL_CYCLES = 16;
    localparam logic [APB_ADDR_W-1:0] WINDOW_ADDR = APB_ADDR_W'(4 * REG_IDX_WINDOW);

    class peak_scoreboard;
        bit [WORD_W-1:0]   stamps [FIFO_DEPTH_DEFAULT];
        bit [WORD_W-1:0]   numbers [FIFO_DEPTH_DEFAULT];
        int unsigned       head;
        int unsigned       tail;
        int unsigned       fill;
        bit [WORD_W-1:0]   record_no;
        bit [WORD_W-1:0]   peak_count;
        bit [WORD_W-1:0]   peak_begin;
        bit [WORD_W-1:0]   peak_end;
        bit [WORD_W-1:0]   error_count;
        bit [WINDOW_W-1:0] window;
        out_beat_t         pending_results[$];
        int unsigned       errors;

        function new();
            head = 0;
            tail = 0;
            fill = 0;
            record_no = '0;
            peak_count = '0;
            peak_begin = '0;
            peak_end = '0;
            error_count = '0;
            window = WINDOW_RESET;
            errors = 0;
        endfunction

        function void set_window(bit [WINDOW_W-1:0] value);
            window = value;
        endfunction

        function int pending();
            return pending_results.size();
        endfunction

        function void note_record(in_beat_t rec);
            out_beat_t        res;
            bit [WORD_W:0]    span;
            bit [WORD_W-1:0]  count;
            res = '0;
            if (rec.has_time) begin
                if (fill >= FIFO_DEPTH_DEFAULT) begin
                    head = (head + 1) % FIFO_DEPTH_DEFAULT;
                    fill--;
                    res.overflow = 1'b1;
                end
                stamps[tail] = rec.timestamp;
                numbers[tail] = record_no;
                tail = (tail + 1) % FIFO_DEPTH_DEFAULT;
                fill++;
                while (fill > 0 && rec.timestamp > stamps[head]
                       && (rec.timestamp - stamps[head]) > {8'd0, window}) begin
                    head = (head + 1) % FIFO_DEPTH_DEFAULT;
                    fill--;
                end
                span = {1'b0, record_no - numbers[head]} + 33'd1;
                count = span[WORD_W] ? WORD_MAX : span[WORD_W-1:0];
                res.window_count = count;
                if (count > peak_count) begin
                    peak_count = count;
                    peak_begin = stamps[head];
                    peak_end = rec.timestamp;
                end
            end
            if (rec.server_error && error_count != WORD_MAX) begin
                error_count++;
            end
            record_no++;
            res.best_count = peak_count;
            res.best_begin = peak_begin;
            res.best_end = peak_end;
            res.error_total = error_count;
            pending_results.push_back(res);
        endfunction

        function void compare(string field, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t: %s mismatch: expected %h, got %h", $time, field, want, got);
            end
        endfunction

        function void check_result(out_beat_t got);
            out_beat_t want;
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result beat: expected none, got %h", $time, got);
            end else begin
                want = pending_results.pop_front();
                compare("window_count", want.window_count, got.window_count);
                compare("best_count", want.best_count, got.best_count);
                compare("best_begin", want.best_begin, got.best_begin);
                compare("best_end", want.best_end, got.best_end);
                compare("error_total", want.error_total, got.error_total);
                compare("overflow", WORD_W'(want.overflow), WORD_W'(got.overflow));
            end
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    in_beat_t              s_data;
    logic                  m_valid;
    logic                  m_ready;
    out_beat_t             m_data;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [WORD_W-1:0]     pwdata;
    logic [WORD_W-1:0]     prdata;
    logic                  pready;

    peak_scoreboard  sb;
    bit              sender_fast;
    bit              receiver_fast;
    bit              hold_request;
    bit [WORD_W-1:0] stamp_now;
    int unsigned     idle_cycles;

    sliding_window_peak_counter_core u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((m_valid && m_ready) || (s_valid && s_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (m_valid && m_ready) begin
                sb.check_result(m_data);
            end
            if (s_valid && s_ready) begin
                sb.note_record(s_data);
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial begin
        int unsigned gap;
        while (!aresetn) @(negedge aclk);
        forever begin
            gap = receiver_fast ? 0 : $urandom_range(0, 9);
            if (hold_request) begin
                hold_request = 1'b0;
                gap = HOLD_CYCLES;
            end
            repeat (gap) begin
                m_ready <= 1'b0;
                @(negedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            @(negedge aclk);
        end
    end

    function automatic in_beat_t make_record(bit has_time, bit [WORD_W-1:0] stamp, bit err);
        in_beat_t rec;
        rec.has_time = has_time;
        rec.timestamp = stamp;
        rec.server_error = err;
        return rec;
    endfunction

    function automatic in_beat_t random_record(int unsigned step, bit clean);
        in_beat_t rec;
        rec.server_error = ($urandom_range(0, 3) == 0);
        rec.has_time = clean ? ($urandom_range(0, 31) != 0) : ($urandom_range(0, 7) != 0);
        if (!rec.has_time) begin
            rec.timestamp = $urandom;
        end else begin
            case (clean ? 2 : $urandom_range(0, 15))
                0: begin
                    stamp_now = $urandom;
                end
                1: begin
                    stamp_now = stamp_now - $urandom_range(0, step);
                end
                default: begin
                    stamp_now = stamp_now + $urandom_range(0, step);
                end
            endcase
            rec.timestamp = stamp_now;
        end
        return rec;
    endfunction

    task automatic send_record(in_beat_t rec);
        int unsigned gap;
        gap = sender_fast ? 0 : $urandom_range(0, 9);
        repeat (gap) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= rec;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        while (sb.pending() != 0) @(negedge aclk);
    endtask

    task automatic apb_access(bit write, bit [WORD_W-1:0] wdata, output logic [WORD_W-1:0] rdata);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= write;
        paddr <= WINDOW_ADDR;
        pwdata <= wdata;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        rdata = prdata;
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic check_window_register();
        logic [WORD_W-1:0] rdata;
        apb_access(1'b0, '0, rdata);
        if (rdata[WINDOW_W-1:0] !== sb.window) begin
            sb.errors++;
            $display("%0t: window_seconds readback mismatch: expected %h, got %h",
                     $time, sb.window, rdata[WINDOW_W-1:0]);
        end
    endtask

    task automatic change_window(bit [WORD_W-1:0] value);
        logic [WORD_W-1:0] unused;
        s_valid <= 1'b0;
        wait_drained();
        apb_access(1'b1, value, unused);
        sb.set_window(value[WINDOW_W-1:0]);
        check_window_register();
    endtask

    task automatic run_phase(bit [WORD_W-1:0] window_value, int unsigned step, int unsigned count,
                             bit clean, bit fast_send, bit fast_recv, bit hold_mid,
                             bit pause_mid);
        change_window(window_value);
        sender_fast = fast_send;
        receiver_fast = fast_recv;
        for (int unsigned i = 0; i < count; i++) begin
            if (i == count / 2) begin
                if (hold_mid) begin
                    hold_request = 1'b1;
                end
                if (pause_mid) begin
                    s_valid <= 1'b0;
                    wait_drained();
                end
            end
            send_record(random_record(step, clean));
        end
    endtask

    initial begin
        sb = new();
        aclk = 1'b0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        m_ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        sender_fast = 1'b0;
        receiver_fast = 1'b0;
        hold_request = 1'b0;
        stamp_now = '0;
        idle_cycles = 0;
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        check_window_register();

        // Default window: boundary ages, decreasing stamps and the extremes of the stamp range.
        send_record(make_record(1'b0, 32'hFFFF_FFFF, 1'b1));
        send_record(make_record(1'b1, 32'h0000_0000, 1'b0));
        send_record(make_record(1'b1, 32'h0000_0000, 1'b1));
        send_record(make_record(1'b1, 32'd60, 1'b0));
        send_record(make_record(1'b1, 32'd61, 1'b0));
        send_record(make_record(1'b1, 32'd61, 1'b1));
        send_record(make_record(1'b1, 32'd30, 1'b0));
        send_record(make_record(1'b0, 32'h0000_0000, 1'b0));
        send_record(make_record(1'b1, 32'd200, 1'b1));
        send_record(make_record(1'b1, 32'hFFFF_FFFF, 1'b0));
        send_record(make_record(1'b1, 32'hFFFF_FFFF, 1'b1));
        send_record(make_record(1'b1, 32'hFFFF_FF00, 1'b0));
        send_record(make_record(1'b1, 32'h0000_0000, 1'b0));

        change_window(32'd0);
        send_record(make_record(1'b1, 32'd5, 1'b0));
        send_record(make_record(1'b1, 32'd5, 1'b1));
        send_record(make_record(1'b1, 32'd6, 1'b0));

        // Upper data bits lie outside the register and must be ignored.
        change_window({8'hA5, 24'hFF_FFFF});
        send_record(make_record(1'b1, 32'h0000_0000, 1'b0));
        send_record(make_record(1'b1, 32'h00FF_FFFF, 1'b0));
        send_record(make_record(1'b1, 32'h0100_0000, 1'b1));

        change_window(32'd1);
        send_record(make_record(1'b1, 32'd100, 1'b0));
        send_record(make_record(1'b1, 32'd101, 1'b0));
        send_record(make_record(1'b1, 32'd102, 1'b1));

        run_phase(32'd60, 20, 150, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0);
        run_phase(32'd0, 2, 120, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        // A wide window with slowly rising stamps fills the FIFO until it overflows.
        run_phase(32'hFF_FFFF, 3, 1150, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1);
        run_phase(32'd5, 10, 150, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0);
        stamp_now = $urandom;
        run_phase($urandom_range(1, 1000), $urandom_range(1, 400), 150, 1'b0, 1'b0, 1'b0,
                  1'b0, 1'b0);
        run_phase(32'd60, 30, 80, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);

        s_valid <= 1'b0;
        wait_drained();
        repeat (TAIL_CYCLES) @(negedge aclk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
